@@ design/png_unf_pkg.sv @@
// ----------------------------------------------------------------------------
// png_unf_pkg
// Shared constants, codes and byte predictors for the PNG scanline unfilter.
// ----------------------------------------------------------------------------
package png_unf_pkg;

  localparam int DEFAULT_MAX_WIDTH = 4096;

  localparam int FILT_W     = 3;
  localparam int CHAN_W     = 8;
  localparam int PIX_W      = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;
  localparam int IMG_W_W    = 13;
  localparam int IMG_H_W    = 16;

  // Byte lanes of a packed pixel
  localparam int BLUE_LSB  = 0;
  localparam int GREEN_LSB = 8;
  localparam int RED_LSB   = 16;
  localparam int ALPHA_LSB = 24;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ALPHA_MODE   = 2'd0,
    CFG_IMAGE_WIDTH  = 2'd1,
    CFG_IMAGE_HEIGHT = 2'd2
  } cfg_idx_t;

  typedef enum logic [FILT_W-1:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filt_t;

  function automatic logic [9:0] abs10(logic signed [9:0] v);
    abs10 = (v < 0) ? 10'(-v) : 10'(v);
  endfunction

  // Paeth predictor, ties go to left, then above, then upper-left
  function automatic logic [CHAN_W-1:0] paeth(logic [CHAN_W-1:0] a, logic [CHAN_W-1:0] b,
                                             logic [CHAN_W-1:0] c);
    logic [9:0] da;
    logic [9:0] db;
    logic [9:0] dc;
    da = abs10(signed'({2'b00, b}) - signed'({2'b00, c}));
    db = abs10(signed'({2'b00, a}) - signed'({2'b00, c}));
    dc = abs10(signed'({2'b00, a}) + signed'({2'b00, b})
               - signed'({2'b00, c}) - signed'({2'b00, c}));
    if (da <= db && da <= dc) begin
      paeth = a;
    end else if (db <= dc) begin
      paeth = b;
    end else begin
      paeth = c;
    end
  endfunction

  function automatic logic [CHAN_W-1:0] predict(logic [FILT_W-1:0] kind,
                                               logic [CHAN_W-1:0] a,
                                               logic [CHAN_W-1:0] b,
                                               logic [CHAN_W-1:0] c);
    logic [CHAN_W:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    unique case (kind)
      FILT_SUB:   predict = a;
      FILT_UP:    predict = b;
      FILT_AVG:   predict = sum[CHAN_W:1];
      FILT_PAETH: predict = paeth(a, b, c);
      default:    predict = '0;
    endcase
  endfunction

endpackage

@@ design/png_unf_if.sv @@
// ----------------------------------------------------------------------------
// png_unf_if
// Channel interfaces: filtered pixel in, reconstructed pixel out, config write.
// ----------------------------------------------------------------------------
interface png_unf_in_if;
  import png_unf_pkg::*;

  logic              valid;
  logic              ready;
  logic [FILT_W-1:0] filter_type;
  logic [CHAN_W-1:0] chan_red;
  logic [CHAN_W-1:0] chan_green;
  logic [CHAN_W-1:0] chan_blue;
  logic [CHAN_W-1:0] chan_alpha;

  modport source (output valid, filter_type, chan_red, chan_green, chan_blue, chan_alpha,
                  input ready);
  modport sink   (input valid, filter_type, chan_red, chan_green, chan_blue, chan_alpha,
                  output ready);
endinterface

interface png_unf_out_if;
  import png_unf_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_word;
  logic             last_in_row;
  logic             last_in_image;

  modport source (output valid, pixel_word, last_in_row, last_in_image, input ready);
  modport sink   (input valid, pixel_word, last_in_row, last_in_image, output ready);
endinterface

interface png_unf_cfg_if;
  import png_unf_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ design/png_scanline_unfilter.sv @@
// ----------------------------------------------------------------------------
// png_scanline_unfilter
// Reverses the PNG row filter (None, Sub, Up, Average, Paeth) one pixel a time.
// ----------------------------------------------------------------------------
// Takes one filtered RGB/RGBA pixel per cycle and returns one reconstructed
// pixel per cycle unless the output stalls, through the compute stage and the
// output register. The rate is set by the line store, which has one read and
// one write port and is touched once each per pixel: the entry above is read
// as the request is taken and the new pixel written as it leaves the compute
// stage. The line store needs no clearing after reset since the first row of
// every image ignores it. The user must write configuration, over its own
// always-ready channel, only while no pixel is in flight; nothing enforces it.
module png_scanline_unfilter #(
  parameter int MAX_WIDTH = png_unf_pkg::DEFAULT_MAX_WIDTH
) (
  input  logic          clk,
  input  logic          rst,
  png_unf_cfg_if.sink   cfg,
  png_unf_in_if.sink    pix_in,
  png_unf_out_if.source pix_out
);
  import png_unf_pkg::*;

  localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int CNT_W = $clog2(MAX_WIDTH + 1);

  typedef struct packed {
    logic [COL_W-1:0]  col;
    logic              col_first;
    logic              row_first;
    logic              end_row;
    logic              end_img;
    logic [FILT_W-1:0] filt;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } stage_t;

  // Configuration
  logic               alpha_mode;
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  // Raster position on the request side
  logic [COL_W-1:0]   col_cnt;
  logic [IMG_H_W-1:0] row_cnt;
  logic [FILT_W-1:0]  row_filter;

  // Compute stage
  logic             s1_valid;
  stage_t           s1;
  stage_t           s1_next;
  logic [PIX_W-1:0] above_rd;
  logic             above_fwd;
  logic [PIX_W-1:0] fwd_pix;
  logic [PIX_W-1:0] left_pixel;
  logic [PIX_W-1:0] upper_left_pixel;

  logic [PIX_W-1:0] line_mem [MAX_WIDTH];

  // Output register
  logic             out_valid;
  logic [PIX_W-1:0] out_pix;
  logic             out_last_row;
  logic             out_last_img;

  logic               out_free;
  logic               s1_adv;
  logic               accept;
  logic [CNT_W-1:0]   w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [CNT_W-1:0]   col_inc;
  logic [IMG_H_W:0]   row_inc;
  logic               end_row;
  logic               end_img;
  logic [PIX_W-1:0]   a_pix;
  logic [PIX_W-1:0]   b_pix;
  logic [PIX_W-1:0]   c_pix;
  logic [PIX_W-1:0]   result;

  assign out_free     = !out_valid || pix_out.ready;
  assign s1_adv       = s1_valid && out_free;
  assign pix_in.ready = !s1_valid || out_free;
  assign accept       = pix_in.valid && pix_in.ready;
  assign cfg.ready    = 1'b1;

  // Clamp the configured size into the legal range
  always_comb begin
    if (image_width == '0) begin
      w_eff = CNT_W'(1);
    end else if (32'(image_width) > 32'(MAX_WIDTH)) begin
      w_eff = CNT_W'(MAX_WIDTH);
    end else begin
      w_eff = CNT_W'(image_width);
    end
    h_eff = (image_height == '0) ? IMG_H_W'(1) : image_height;
  end

  assign col_inc = CNT_W'(col_cnt) + CNT_W'(1);
  assign row_inc = {1'b0, row_cnt} + (IMG_H_W+1)'(1);
  assign end_row = (col_inc >= w_eff);
  assign end_img = end_row && (row_inc >= {1'b0, h_eff});

  always_comb begin
    s1_next.col       = col_cnt;
    s1_next.col_first = (col_cnt == '0);
    s1_next.row_first = (row_cnt == '0);
    s1_next.end_row   = end_row;
    s1_next.end_img   = end_img;
    s1_next.filt      = (col_cnt == '0) ? pix_in.filter_type : row_filter;
    s1_next.red       = pix_in.chan_red;
    s1_next.green     = pix_in.chan_green;
    s1_next.blue      = pix_in.chan_blue;
    s1_next.alpha     = pix_in.chan_alpha;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_mode   <= 1'b0;
      image_width  <= IMG_W_W'(1);
      image_height <= IMG_H_W'(1);
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_ALPHA_MODE:   alpha_mode   <= cfg.data[0];
        CFG_IMAGE_WIDTH:  image_width  <= cfg.data[IMG_W_W-1:0];
        CFG_IMAGE_HEIGHT: image_height <= cfg.data[IMG_H_W-1:0];
        default:          ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt    <= '0;
      row_cnt    <= '0;
      row_filter <= FILT_NONE;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        row_filter <= s1_next.filt;
        if (end_row) begin
          col_cnt <= '0;
          row_cnt <= end_img ? '0 : row_inc[IMG_H_W-1:0];
        end else begin
          col_cnt <= col_inc[COL_W-1:0];
        end
      end
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= s1_next;
    end
  end

  // Line store: read the entry above on request, write the new pixel on exit.
  // A read of the entry being written this cycle takes the new pixel instead.
  always_ff @(posedge clk) begin
    if (accept) begin
      above_rd  <= line_mem[col_cnt];
      above_fwd <= s1_adv && (s1.col == col_cnt);
      fwd_pix   <= result;
    end
    if (s1_adv) begin
      line_mem[s1.col] <= result;
    end
  end

  always_comb begin
    a_pix = s1.col_first ? '0 : left_pixel;
    if (s1.row_first) begin
      b_pix = '0;
    end else begin
      b_pix = above_fwd ? fwd_pix : above_rd;
    end
    c_pix = (s1.row_first || s1.col_first) ? '0 : upper_left_pixel;

    result[BLUE_LSB +: CHAN_W] = s1.blue + predict(s1.filt, a_pix[BLUE_LSB +: CHAN_W],
        b_pix[BLUE_LSB +: CHAN_W], c_pix[BLUE_LSB +: CHAN_W]);
    result[GREEN_LSB +: CHAN_W] = s1.green + predict(s1.filt, a_pix[GREEN_LSB +: CHAN_W],
        b_pix[GREEN_LSB +: CHAN_W], c_pix[GREEN_LSB +: CHAN_W]);
    result[RED_LSB +: CHAN_W] = s1.red + predict(s1.filt, a_pix[RED_LSB +: CHAN_W],
        b_pix[RED_LSB +: CHAN_W], c_pix[RED_LSB +: CHAN_W]);
    result[ALPHA_LSB +: CHAN_W] = s1.alpha + predict(s1.filt, a_pix[ALPHA_LSB +: CHAN_W],
        b_pix[ALPHA_LSB +: CHAN_W], c_pix[ALPHA_LSB +: CHAN_W]);
    // Drop alpha in RGB mode
    if (!alpha_mode) begin
      result[ALPHA_LSB +: CHAN_W] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      left_pixel       <= result;
      upper_left_pixel <= b_pix;
      out_pix          <= result;
      out_last_row     <= s1.end_row;
      out_last_img     <= s1.end_img;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (pix_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  assign pix_out.valid         = out_valid;
  assign pix_out.pixel_word    = out_pix;
  assign pix_out.last_in_row   = out_last_row;
  assign pix_out.last_in_image = out_last_img;

endmodule

@@ design/png_unf_checker.sv @@
// ----------------------------------------------------------------------------
// png_unf_checker
// Port-level checks for the scanline unfilter, bound to the top level.
// ----------------------------------------------------------------------------
module png_unf_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_pixel_word,
  input logic        out_last_row,
  input logic        out_last_img
);

  logic in_take;
  assign in_take = in_valid && in_ready;

  // The end of an image is always the end of a row
  a_img_ends_row: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_last_row || !out_last_img))
    else $error("last_in_image without last_in_row");

  // A fresh result comes from a request that passed through the compute stage
  a_out_from_in: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_take, 2))
    else $error("result appeared with no matching request");

  // Two stalled slots hold at most two pixels, so stop taking requests
  a_full_stalls_in: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready && in_take) ##1 !out_ready |-> !in_ready)
    else $error("request taken with both stages full");

  // Stalled result holds still
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_pixel_word) && $stable(out_last_row)
       && $stable(out_last_img)))
    else $error("stalled result changed");

endmodule

bind png_scanline_unfilter png_unf_checker u_png_unf_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (pix_in.valid),
  .in_ready       (pix_in.ready),
  .out_valid      (pix_out.valid),
  .out_ready      (pix_out.ready),
  .out_pixel_word (pix_out.pixel_word),
  .out_last_row   (pix_out.last_in_row),
  .out_last_img   (pix_out.last_in_image)
);

@@ dv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PNG scanline unfilter: random RGB/RGBA rows with
// every row filter, image sizes changed at and between image boundaries, a
// local pixel predictor and an in-order scoreboard, random stalls both sides.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import png_unf_pkg::*;

  localparam int LINE_DEPTH = DEFAULT_MAX_WIDTH;
  localparam int RAND_ITEMS = 450;
  localparam int WIDE_ROW = 64;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 10;

  // Filter codes with no name in the package; they all act as None
  localparam logic [FILT_W-1:0] FILT_RSVD5 = 3'd5;
  localparam logic [FILT_W-1:0] FILT_RSVD7 = 3'd7;

  typedef struct packed {
    logic [FILT_W-1:0] filt;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;
  } pix_item_t;

  typedef struct packed {
    logic [PIX_W-1:0] word;
    logic             row_end;
    logic             img_end;
  } recon_t;

  logic clk = 1'b0;
  logic rst;

  png_unf_cfg_if cfg_ch ();
  png_unf_in_if  in_ch ();
  png_unf_out_if out_ch ();

  png_scanline_unfilter dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .pix_in  (in_ch),
    .pix_out (out_ch)
  );

  always #5 clk = ~clk;

  // Predictor copy of the block's registers and state
  logic             cur_alpha  = 1'b0;
  logic [IMG_W_W-1:0] cur_width = 13'd1;
  logic [IMG_H_W-1:0] cur_height = 16'd1;
  logic [PIX_W-1:0] line_mem [LINE_DEPTH];
  bit               line_seen [LINE_DEPTH];
  logic [PIX_W-1:0] left_px   = '0;
  logic [PIX_W-1:0] upleft_px = '0;
  int               col_cnt   = 0;
  int               row_cnt   = 0;
  logic [FILT_W-1:0] row_filt = FILT_NONE;

  pix_item_t pend_q [$];
  recon_t    recon_q [$];

  bit        in_taken;
  bit        calm;
  int        send_gap;
  int        hold_left;
  int        errors;
  int        cycles;
  int        rand_sent;
  pix_item_t nxt;
  recon_t    want;

  function automatic int eff_width(logic [IMG_W_W-1:0] w);
    if (w == 0) return 1;
    if (w > LINE_DEPTH) return LINE_DEPTH;
    return int'(w);
  endfunction

  function automatic logic [CHAN_W-1:0] guess_byte(logic [FILT_W-1:0] kind,
                                                   logic [CHAN_W-1:0] a,
                                                   logic [CHAN_W-1:0] b,
                                                   logic [CHAN_W-1:0] c);
    int p;
    int da;
    int db;
    int dc;
    case (kind)
      FILT_SUB:   return a;
      FILT_UP:    return b;
      FILT_AVG:   return CHAN_W'((int'(a) + int'(b)) >> 1);
      FILT_PAETH: begin
        p  = int'(a) + int'(b) - int'(c);
        da = (p > int'(a)) ? p - int'(a) : int'(a) - p;
        db = (p > int'(b)) ? p - int'(b) : int'(b) - p;
        dc = (p > int'(c)) ? p - int'(c) : int'(c) - p;
        if (da <= db && da <= dc) return a;
        if (db <= dc) return b;
        return c;
      end
      default:    return '0;
    endcase
  endfunction

  function automatic recon_t reconstruct(pix_item_t it);
    recon_t           res;
    int               w;
    int               h;
    int               c;
    logic [PIX_W-1:0] above;
    logic [PIX_W-1:0] diag;
    logic [PIX_W-1:0] raw;
    logic [PIX_W-1:0] word;
    w = eff_width(cur_width);
    h = (cur_height == 0) ? 1 : int'(cur_height);
    c = (col_cnt >= LINE_DEPTH) ? 0 : col_cnt;
    if (c == 0) begin
      row_filt  = it.filt;
      left_px   = '0;
      upleft_px = '0;
    end
    above = (row_cnt == 0) ? '0 : line_mem[c];
    diag  = (row_cnt == 0) ? '0 : upleft_px;
    raw   = {it.alpha, it.red, it.green, it.blue};
    for (int k = 0; k < 4; k++) begin
      word[8*k +: 8] = raw[8*k +: 8] +
                       guess_byte(row_filt, left_px[8*k +: 8], above[8*k +: 8], diag[8*k +: 8]);
    end
    if (!cur_alpha) word[ALPHA_LSB +: CHAN_W] = '0;
    line_mem[c]  = word;
    line_seen[c] = 1'b1;
    left_px      = word;
    upleft_px    = above;
    res.word     = word;
    res.row_end  = (c + 1 >= w);
    res.img_end  = 1'b0;
    if (res.row_end) begin
      col_cnt = 0;
      if (row_cnt + 1 >= h) begin
        res.img_end = 1'b1;
        row_cnt     = 0;
      end else begin
        row_cnt = row_cnt + 1;
      end
    end else begin
      col_cnt = c + 1;
    end
    return res;
  endfunction

  // Columns a later row may read must all have been written since reset
  function automatic bit store_covers(int w);
    for (int i = 0; i < w; i++) begin
      if (!line_seen[i]) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic logic [CHAN_W-1:0] pick_byte(bit vivid);
    if (!vivid) return CHAN_W'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0:       return 8'h00;
      1:       return 8'h01;
      2:       return 8'h7f;
      3:       return 8'h80;
      4:       return 8'hfe;
      default: return 8'hff;
    endcase
  endfunction

  task automatic note_bad(string msg);
    errors++;
    $display("mismatch @%0d: %s", cycles, msg);
  endtask

  task automatic queue_pixel(logic [FILT_W-1:0] f, logic [CHAN_W-1:0] r, logic [CHAN_W-1:0] g,
                             logic [CHAN_W-1:0] b, logic [CHAN_W-1:0] a);
    pix_item_t it;
    it = '{filt: f, red: r, green: g, blue: b, alpha: a};
    pend_q.push_back(it);
  endtask

  task automatic queue_random(int n, bit vivid);
    logic [FILT_W-1:0] f;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 85) f = FILT_W'($urandom_range(FILT_NONE, FILT_PAETH));
      else f = FILT_W'($urandom_range(FILT_RSVD5, FILT_RSVD7));
      queue_pixel(f, pick_byte(vivid), pick_byte(vivid), pick_byte(vivid), pick_byte(vivid));
    end
  endtask

  // Hold until every request is taken and every pixel has come back
  task automatic drain();
    while (pend_q.size() != 0 || in_ch.valid || recon_q.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
  endtask

  task automatic cfg_done();
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic configure(logic [CFG_DATA_W-1:0] alpha_d, logic [CFG_DATA_W-1:0] width_d,
                           logic [CFG_DATA_W-1:0] height_d);
    cfg_write(CFG_ALPHA_MODE, alpha_d);
    cfg_write(CFG_IMAGE_WIDTH, width_d);
    cfg_write(CFG_IMAGE_HEIGHT, height_d);
    cfg_done();
  endtask

  task automatic random_phase();
    logic [CFG_DATA_W-1:0] wdata;
    logic [CFG_DATA_W-1:0] hdata;
    int r;
    int w_eff;
    int h_eff;
    int n;
    int part;
    bit vivid;
    drain();
    r = $urandom_range(0, 99);
    if (r < 5) wdata = '0;
    else if (r < 10) wdata = 16'h2000 | CFG_DATA_W'($urandom_range(1, 8));
    else if (r < 75) wdata = CFG_DATA_W'($urandom_range(1, 8));
    else wdata = CFG_DATA_W'($urandom_range(9, 48));
    w_eff = eff_width(wdata[IMG_W_W-1:0]);
    // mid-image, a wider row would read columns never written
    if (row_cnt != 0 && !store_covers(w_eff)) begin
      wdata = 16'd1;
      w_eff = 1;
    end
    hdata = ($urandom_range(0, 99) < 8) ? '0 : CFG_DATA_W'($urandom_range(1, 4));
    h_eff = (hdata == 0) ? 1 : int'(hdata);
    configure(CFG_DATA_W'($urandom), wdata, hdata);
    calm  = ($urandom_range(0, 4) == 0);
    vivid = ($urandom_range(0, 2) == 0);
    n = w_eff * h_eff * ((w_eff > 8) ? 1 : $urandom_range(1, 3));
    if ($urandom_range(0, 2) == 0) n += $urandom_range(1, w_eff * h_eff);
    if (n > RAND_ITEMS - rand_sent) n = RAND_ITEMS - rand_sent;
    if (n > 1 && $urandom_range(0, 3) == 0) begin
      part = $urandom_range(1, n - 1);
      queue_random(part, vivid);
      drain();
      queue_random(n - part, vivid);
    end else begin
      queue_random(n, vivid);
    end
    rand_sent += n;
  endtask

  // Request driver
  always @(negedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
    end else if (in_ch.valid && !in_taken) begin
      // hold the request until it is taken
    end else if (send_gap > 0 || pend_q.size() == 0) begin
      in_ch.valid <= 1'b0;
      if (send_gap > 0) send_gap--;
    end else begin
      nxt = pend_q.pop_front();
      in_ch.filter_type <= nxt.filt;
      in_ch.chan_red    <= nxt.red;
      in_ch.chan_green  <= nxt.green;
      in_ch.chan_blue   <= nxt.blue;
      in_ch.chan_alpha  <= nxt.alpha;
      in_ch.valid       <= 1'b1;
      send_gap = calm ? 0 : pick_gap();
    end
  end

  // Result back-pressure
  always @(negedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
    end else if (calm) begin
      out_ch.ready <= 1'b1;
    end else if (hold_left > 0) begin
      out_ch.ready <= 1'b0;
      hold_left--;
    end else begin
      out_ch.ready <= 1'b1;
      hold_left = pick_gap();
    end
  end

  // Monitor and scoreboard
  always @(posedge clk) begin
    in_taken = 1'b0;
    if (!rst) begin
      in_taken = in_ch.valid && in_ch.ready;
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.index)
          CFG_ALPHA_MODE:   cur_alpha  = cfg_ch.data[0];
          CFG_IMAGE_WIDTH:  cur_width  = cfg_ch.data[IMG_W_W-1:0];
          CFG_IMAGE_HEIGHT: cur_height = cfg_ch.data[IMG_H_W-1:0];
          default: ;
        endcase
      end
      if (in_taken) begin
        recon_q.push_back(reconstruct('{filt: in_ch.filter_type, red: in_ch.chan_red,
                                        green: in_ch.chan_green, blue: in_ch.chan_blue,
                                        alpha: in_ch.chan_alpha}));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (recon_q.size() == 0) begin
          note_bad($sformatf("pixel %08h with none pending", out_ch.pixel_word));
        end else begin
          want = recon_q.pop_front();
          if (out_ch.pixel_word !== want.word)
            note_bad($sformatf("pixel_word %08h, want %08h", out_ch.pixel_word, want.word));
          if (out_ch.last_in_row !== want.row_end)
            note_bad($sformatf("last_in_row %b, want %b", out_ch.last_in_row, want.row_end));
          if (out_ch.last_in_image !== want.img_end)
            note_bad($sformatf("last_in_image %b, want %b", out_ch.last_in_image,
                               want.img_end));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("[png_scanline_unfilter] ERROR");
      $finish;
    end
  end

  initial begin
    rst               = 1'b1;
    cfg_ch.valid      = 1'b0;
    cfg_ch.index      = CFG_ALPHA_MODE;
    cfg_ch.data       = '0;
    in_ch.valid       = 1'b0;
    in_ch.filter_type = FILT_NONE;
    in_ch.chan_red    = '0;
    in_ch.chan_green  = '0;
    in_ch.chan_blue   = '0;
    in_ch.chan_alpha  = '0;
    out_ch.ready      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset sizes: one-pixel RGB image, alpha byte must be dropped
    queue_pixel(FILT_NONE, 8'hff, 8'hff, 8'hff, 8'hff);
    drain();

    // 3x4 RGBA, one filter per row, wrap-around bytes
    configure(16'd1, 16'd3, 16'd4);
    queue_pixel(FILT_SUB,   8'h10, 8'h20, 8'h30, 8'h40);
    queue_pixel(FILT_PAETH, 8'hff, 8'hf0, 8'he0, 8'hd0);
    queue_pixel(FILT_UP,    8'h01, 8'h02, 8'h03, 8'h04);
    queue_pixel(FILT_UP,    8'h80, 8'h7f, 8'h00, 8'hff);
    queue_pixel(FILT_SUB,   8'hff, 8'h00, 8'h80, 8'h01);
    queue_pixel(FILT_NONE,  8'h00, 8'hff, 8'hfe, 8'h7f);
    queue_pixel(FILT_AVG,   8'hff, 8'hff, 8'hff, 8'hff);
    queue_pixel(FILT_AVG,   8'h01, 8'h80, 8'hfe, 8'h00);
    queue_pixel(FILT_UP,    8'h80, 8'h01, 8'h7f, 8'hff);
    queue_pixel(FILT_PAETH, 8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(FILT_NONE,  8'h00, 8'h00, 8'h00, 8'h00);
    queue_pixel(FILT_SUB,   8'hff, 8'h01, 8'h80, 8'h7f);
    drain();

    // Zero width and height act as one; alpha bit clear under high data bits
    configure(16'hfffe, 16'h2000, 16'h0000);
    queue_pixel(FILT_RSVD5, 8'h12, 8'h34, 8'h56, 8'h78);
    queue_pixel(3'(FILT_RSVD5 + 1), 8'h9a, 8'hbc, 8'hde, 8'hf0);
    drain();

    // Width saturates, then shrinks below the current column mid-row
    configure(16'hffff, 16'hffff, 16'd2);
    queue_pixel(FILT_RSVD7, 8'h11, 8'h22, 8'h33, 8'h44);
    queue_pixel(FILT_SUB,   8'h55, 8'h66, 8'h77, 8'h88);
    queue_pixel(FILT_SUB,   8'h99, 8'haa, 8'hbb, 8'hcc);
    queue_pixel(FILT_SUB,   8'hdd, 8'hee, 8'hff, 8'h00);
    drain();
    cfg_write(CFG_IMAGE_WIDTH, 16'd2);
    cfg_done();
    queue_pixel(FILT_NONE,  8'h01, 8'h02, 8'h03, 8'h04);
    queue_pixel(FILT_PAETH, 8'h10, 8'hf0, 8'h80, 8'h7f);
    queue_pixel(FILT_NONE,  8'hff, 8'h00, 8'hff, 8'h00);
    drain();

    // Tallest image, cut short by lowering the height mid-image
    configure(16'd0, 16'd1, 16'hffff);
    queue_pixel(FILT_UP,    8'h40, 8'h80, 8'hc0, 8'hff);
    queue_pixel(FILT_AVG,   8'hc0, 8'h80, 8'h40, 8'h01);
    queue_pixel(FILT_PAETH, 8'h01, 8'hff, 8'h7f, 8'h80);
    drain();
    cfg_write(CFG_IMAGE_HEIGHT, 16'd2);
    cfg_done();
    queue_pixel(FILT_UP,    8'h05, 8'h06, 8'h07, 8'h08);
    queue_pixel(FILT_PAETH, 8'hfe, 8'hfd, 8'hfc, 8'hfb);
    queue_pixel(FILT_SUB,   8'h3c, 8'hc3, 8'h5a, 8'ha5);
    drain();

    // Wide image so a long row of the line store is read back
    configure(CFG_DATA_W'($urandom), CFG_DATA_W'(WIDE_ROW), 16'd2);
    calm = 1'b1;
    queue_random(2 * WIDE_ROW, 1'b0);

    while (rand_sent < RAND_ITEMS) random_phase();

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (recon_q.size() != 0) note_bad($sformatf("%0d pixels never came", recon_q.size()));
    if (errors == 0) begin
      $display("[png_scanline_unfilter] OK");
    end else begin
      $display("[png_scanline_unfilter] ERROR");
    end
    $finish;
  end

endmodule
